@@ hw/rtl/ofsb_pkg.sv @@
// ----------------------------------------------------------------------------
// ofsb_pkg
// Shared types and constants of the oldest-first slot buffer.
// ----------------------------------------------------------------------------
package ofsb_pkg;

    localparam int SLOT_COUNT    = 8;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int IDX_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W         = $clog2(SLOT_COUNT + 1);
    localparam int ENTRY_W       = 64 + PAYLOAD_WIDTH + 1 + 1 + 64;

    localparam logic [2:0] KIND_PUBLISH = 3'd0;
    localparam logic [2:0] KIND_CONSUME = 3'd1;
    localparam logic [2:0] KIND_DISC    = 3'd2;
    localparam logic [2:0] KIND_DISC_KB = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;

    localparam logic [2:0] SEL_ATTEMPTED = 3'd0;
    localparam logic [2:0] SEL_PUBLISHED = 3'd1;
    localparam logic [2:0] SEL_RECLAIMED = 3'd2;
    localparam logic [2:0] SEL_DROPPED   = 3'd3;
    localparam logic [2:0] SEL_CONSUMED  = 3'd4;
    localparam logic [2:0] SEL_DISCARDED = 3'd5;
    localparam logic [2:0] SEL_HIGH      = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the command
        logic scan_clr;  // restart the slot scan
        logic scan_step; // examine one slot
        logic finish;    // apply the chosen action and form the result
    } ofsb_cmd_t;

    typedef struct packed {
        logic scan_last; // the slot under examination is the last one
    } ofsb_stat_t;

endpackage

@@ hw/rtl/ofsb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ofsb_ctrl
// Sequencer: capture, scan every slot once, then finish and strobe.
// ----------------------------------------------------------------------------
module ofsb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ofsb_pkg::ofsb_stat_t stat,
    output ofsb_pkg::ofsb_cmd_t  cmd,
    output logic                busy,
    output logic                done
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

`ifndef SYNTH
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("done without finish step");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load while busy");
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |=> state_reg == ST_IDLE)
        else $error("finish did not return to idle");
`endif

endmodule

@@ hw/rtl/ofsb_datapath.sv @@
// ----------------------------------------------------------------------------
// ofsb_datapath
// Slot store, serial oldest-slot search, counters and result registers.
// ----------------------------------------------------------------------------
module ofsb_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ofsb_pkg::ofsb_cmd_t               cmd,
    output ofsb_pkg::ofsb_stat_t              stat,
    input  logic [2:0]                        kind,
    input  logic [63:0]                       item_sequence,
    input  logic [31:0]                       item_payload,
    input  logic                              item_boundary,
    input  logic                              item_reset_mark,
    input  logic [63:0]                       generation,
    input  logic [2:0]                        counter_select,
    output logic                              was_published,
    output logic                              evicted_oldest,
    output logic                              dropped_incoming,
    output logic                              found,
    output logic [63:0]                       out_sequence,
    output logic [31:0]                       out_payload,
    output logic                              out_boundary,
    output logic                              out_reset_mark,
    output logic [63:0]                       out_generation,
    output logic [3:0]                        ready_count,
    output logic [63:0]                       counter_value
);

    localparam int N  = ofsb_pkg::SLOT_COUNT;
    localparam int IW = ofsb_pkg::IDX_W;
    localparam int CW = ofsb_pkg::CNT_W;
    localparam int PW = ofsb_pkg::PAYLOAD_WIDTH;

    // Captured command.
    logic [2:0]  kind_reg;
    logic [63:0] seq_reg, gen_reg;
    logic [PW-1:0] pay_reg;
    logic        bnd_reg, rst_mark_reg;
    logic [2:0]  sel_reg;

    // Slot store: ready bits in flip-flops, entries with no reset.
    logic [N-1:0]  ready_reg;
    logic [63:0]   sseq_reg [N];
    logic [PW-1:0] spay_reg [N];
    logic          sbnd_reg [N];
    logic          smark_reg [N];
    logic [63:0]   sgen_reg [N];

    logic [63:0] evc_reg [6];
    logic [CW-1:0] high_reg;

    // Scan state.
    logic [IW-1:0] scan_reg;
    logic          free_hit_reg, cons_hit_reg, evict_hit_reg;
    logic [IW-1:0] free_idx_reg, cons_idx_reg, evict_idx_reg;
    logic [63:0]   cons_best_reg, evict_best_reg;
    logic [N-1:0]  keep_reg;

    assign stat.scan_last = (scan_reg == IW'(N - 1));

    logic [CW-1:0] n_ready;
    always_comb
    begin
        n_ready = '0;
        for (int i = 0; i < N; i++)
        begin
            n_ready = n_ready + CW'(ready_reg[i]);
        end
    end

    // One slot examined per cycle.
    logic cur_ready, cur_keep;
    assign cur_ready = ready_reg[scan_reg];
    assign cur_keep  = (kind_reg == ofsb_pkg::KIND_DISC_KB) && (gen_reg != 64'd0) &&
                       sbnd_reg[scan_reg] && smark_reg[scan_reg] &&
                       (sgen_reg[scan_reg] == gen_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= kind;
            seq_reg      <= item_sequence;
            pay_reg      <= item_payload[PW-1:0];
            bnd_reg      <= item_boundary;
            rst_mark_reg <= item_reset_mark;
            gen_reg      <= generation;
            sel_reg      <= counter_select;
        end
        if (cmd.scan_clr)
        begin
            free_hit_reg   <= 1'b0;
            cons_hit_reg   <= 1'b0;
            evict_hit_reg  <= 1'b0;
            free_idx_reg   <= '0;
            cons_idx_reg   <= '0;
            evict_idx_reg  <= '0;
            cons_best_reg  <= '1;
            evict_best_reg <= '1;
            keep_reg       <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (!cur_ready && !free_hit_reg)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= scan_reg;
            end
            if (cur_ready && sseq_reg[scan_reg] < cons_best_reg)
            begin
                cons_hit_reg  <= 1'b1;
                cons_idx_reg  <= scan_reg;
                cons_best_reg <= sseq_reg[scan_reg];
            end
            if (cur_ready && !sbnd_reg[scan_reg] && sseq_reg[scan_reg] < evict_best_reg)
            begin
                evict_hit_reg  <= 1'b1;
                evict_idx_reg  <= scan_reg;
                evict_best_reg <= sseq_reg[scan_reg];
            end
            keep_reg[scan_reg] <= cur_ready && cur_keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_clr)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_step && !stat.scan_last)
        begin
            scan_reg <= scan_reg + IW'(1);
        end
    end

    // Finish step decisions.
    logic          pub_ok;
    logic [IW-1:0] pub_idx;
    logic [N-1:0]  disc_mask;
    logic [CW-1:0] n_after, n_disc;
    assign pub_ok  = free_hit_reg || evict_hit_reg;
    assign pub_idx = free_hit_reg ? free_idx_reg : evict_idx_reg;
    assign disc_mask = ready_reg & ~keep_reg;
    always_comb
    begin
        n_disc = '0;
        for (int i = 0; i < N; i++)
        begin
            n_disc = n_disc + CW'(disc_mask[i]);
        end
    end
    assign n_after = n_ready + CW'(free_hit_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.finish && kind_reg == ofsb_pkg::KIND_PUBLISH && pub_ok)
        begin
            sseq_reg[pub_idx]  <= seq_reg;
            spay_reg[pub_idx]  <= pay_reg;
            sbnd_reg[pub_idx]  <= bnd_reg;
            smark_reg[pub_idx] <= rst_mark_reg;
            sgen_reg[pub_idx]  <= gen_reg;
        end
    end

    logic [N-1:0] ready_next;
    always_comb
    begin
        ready_next = ready_reg;
        case (kind_reg)
            ofsb_pkg::KIND_PUBLISH: if (pub_ok) ready_next[pub_idx] = 1'b1;
            ofsb_pkg::KIND_CONSUME: if (cons_hit_reg) ready_next[cons_idx_reg] = 1'b0;
            ofsb_pkg::KIND_DISC, ofsb_pkg::KIND_DISC_KB: ready_next = ready_reg & keep_reg;
            default: ready_next = ready_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            high_reg  <= '0;
            for (int i = 0; i < 6; i++)
            begin
                evc_reg[i] <= '0;
            end
        end
        else if (cmd.finish)
        begin
            ready_reg <= ready_next;
            case (kind_reg)
                ofsb_pkg::KIND_PUBLISH:
                begin
                    evc_reg[ofsb_pkg::SEL_ATTEMPTED] <= evc_reg[ofsb_pkg::SEL_ATTEMPTED] + 64'd1;
                    if (pub_ok)
                    begin
                        evc_reg[ofsb_pkg::SEL_PUBLISHED] <=
                            evc_reg[ofsb_pkg::SEL_PUBLISHED] + 64'd1;
                        if (n_after > high_reg)
                        begin
                            high_reg <= n_after;
                        end
                    end
                    else
                    begin
                        evc_reg[ofsb_pkg::SEL_DROPPED] <= evc_reg[ofsb_pkg::SEL_DROPPED] + 64'd1;
                    end
                    if (!free_hit_reg && evict_hit_reg)
                    begin
                        evc_reg[ofsb_pkg::SEL_RECLAIMED] <=
                            evc_reg[ofsb_pkg::SEL_RECLAIMED] + 64'd1;
                    end
                end
                ofsb_pkg::KIND_CONSUME:
                begin
                    if (cons_hit_reg)
                    begin
                        evc_reg[ofsb_pkg::SEL_CONSUMED] <= evc_reg[ofsb_pkg::SEL_CONSUMED] + 64'd1;
                    end
                end
                ofsb_pkg::KIND_DISC, ofsb_pkg::KIND_DISC_KB:
                begin
                    evc_reg[ofsb_pkg::SEL_DISCARDED] <=
                        evc_reg[ofsb_pkg::SEL_DISCARDED] + 64'(n_disc);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result registers, loaded on the finish step only.
    logic [CW-1:0] cnt_after;
    always_comb
    begin
        cnt_after = '0;
        for (int i = 0; i < N; i++)
        begin
            cnt_after = cnt_after + CW'(ready_next[i]);
        end
    end

    logic [63:0] cval;
    always_comb
    begin
        cval = '0;
        if (kind_reg == ofsb_pkg::KIND_READ)
        begin
            case (sel_reg)
                ofsb_pkg::SEL_HIGH: cval = 64'(high_reg);
                3'd7:               cval = '0;
                default:            cval = evc_reg[sel_reg];
            endcase
        end
    end

    logic is_pub, is_cons;
    assign is_pub  = (kind_reg == ofsb_pkg::KIND_PUBLISH);
    assign is_cons = (kind_reg == ofsb_pkg::KIND_CONSUME) && cons_hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            was_published    <= is_pub && pub_ok;
            evicted_oldest   <= is_pub && !free_hit_reg && evict_hit_reg;
            dropped_incoming <= is_pub && !pub_ok;
            found            <= is_cons;
            out_sequence     <= is_cons ? sseq_reg[cons_idx_reg] : 64'd0;
            out_payload      <= is_cons ? 32'(spay_reg[cons_idx_reg]) : 32'd0;
            out_boundary     <= is_cons && sbnd_reg[cons_idx_reg];
            out_reset_mark   <= is_cons && smark_reg[cons_idx_reg];
            out_generation   <= is_cons ? sgen_reg[cons_idx_reg] : 64'd0;
            ready_count      <= 4'(cnt_after);
            counter_value    <= cval;
        end
    end

`ifndef SYNTH
    a_high_bound: assert property (@(posedge clk) disable iff (!rst_n)
        high_reg <= CW'(N))
        else $error("high-water mark above slot count");
    a_publish_sets: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && is_pub && pub_ok |=> ready_reg[$past(pub_idx)])
        else $error("published slot not ready");
    a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && is_cons |=> !ready_reg[$past(cons_idx_reg)])
        else $error("consumed slot still ready");
`endif

endmodule

@@ hw/rtl/oldest_first_slot_buffer_with_eviction.sv @@
// ----------------------------------------------------------------------------
// oldest_first_slot_buffer_with_eviction
// Eight-slot drop-oldest buffer with boundary protection and telemetry.
// ----------------------------------------------------------------------------
// Each command is captured at the edge that accepts it. A serial oldest-slot
// search follows, one slot per cycle, then a finish step that updates the
// slots and counters and registers the result. The result is then shown for
// one cycle on done, which the receiver must take, since it cannot stall. busy
// is high from the edge that accepts start until the edge that raises done, so
// a new command can be started in the cycle that the result is presented.
// Every command, including a counter read or an unused kind, yields exactly
// one result transfer.
// ----------------------------------------------------------------------------
module oldest_first_slot_buffer_with_eviction
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [2:0]  kind,
    input  logic [63:0] item_sequence,
    input  logic [31:0] item_payload,
    input  logic        item_boundary,
    input  logic        item_reset_mark,
    input  logic [63:0] generation,
    input  logic [2:0]  counter_select,
    output logic        was_published,
    output logic        evicted_oldest,
    output logic        dropped_incoming,
    output logic        found,
    output logic [63:0] out_sequence,
    output logic [31:0] out_payload,
    output logic        out_boundary,
    output logic        out_reset_mark,
    output logic [63:0] out_generation,
    output logic [3:0]  ready_count,
    output logic [63:0] counter_value
);

    ofsb_pkg::ofsb_cmd_t  cmd;
    ofsb_pkg::ofsb_stat_t stat;

    // The sequencer issues commands; the datapath reports when its scan ends.
    ofsb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ofsb_datapath u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .kind             (kind),
        .item_sequence    (item_sequence),
        .item_payload     (item_payload),
        .item_boundary    (item_boundary),
        .item_reset_mark  (item_reset_mark),
        .generation       (generation),
        .counter_select   (counter_select),
        .was_published    (was_published),
        .evicted_oldest   (evicted_oldest),
        .dropped_incoming (dropped_incoming),
        .found            (found),
        .out_sequence     (out_sequence),
        .out_payload      (out_payload),
        .out_boundary     (out_boundary),
        .out_reset_mark   (out_reset_mark),
        .out_generation   (out_generation),
        .ready_count      (ready_count),
        .counter_value    (counter_value)
    );

`ifndef SYNTH
    a_no_start_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(done))
        else $error("back-to-back result strobes");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");
    a_done_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");
`endif

endmodule

@@ verif/oldest_first_slot_buffer_with_eviction_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oldest_first_slot_buffer_with_eviction_tb
// Self-checking bench for the oldest-first slot buffer. A queue of commands
// feeds a driver and a shadow buffer predicts every result. A monitor then
// compares each done strobe with the oldest predicted result.
// ----------------------------------------------------------------------------
module oldest_first_slot_buffer_with_eviction_tb;

    localparam logic [2:0] SEL_UNUSED = 3'd7;
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
    localparam logic [63:0] SEQ_NEVER = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int HALF_PERIOD = 4;
    localparam int SETTLE_CYCLES = ofsb_pkg::SLOT_COUNT + 8;

    typedef struct {
        logic [2:0]  kind;
        logic [63:0] sequence_tag;
        logic [31:0] payload;
        logic        boundary;
        logic        reset_mark;
        logic [63:0] gen;
        logic [2:0]  sel;
        bit          drain_first;   // hold the command back until all results are in
    } command_t;

    typedef struct packed {
        logic        published;
        logic        evicted;
        logic        dropped;
        logic        got_item;
        logic [63:0] sequence_tag;
        logic [31:0] payload;
        logic        boundary;
        logic        reset_mark;
        logic [63:0] gen;
        logic [3:0]  ready_cnt;
        logic [63:0] counter;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    command_t cur;
    outcome_t seen;

    logic        was_published;
    logic        evicted_oldest;
    logic        dropped_incoming;
    logic        found;
    logic [63:0] out_sequence;
    logic [31:0] out_payload;
    logic        out_boundary;
    logic        out_reset_mark;
    logic [63:0] out_generation;
    logic [3:0]  ready_count;
    logic [63:0] counter_value;

    command_t pending_cmds[$];
    outcome_t expected_outcomes[$];

    // Shadow copy of the slot store and the telemetry.
    logic        shadow_ready[ofsb_pkg::SLOT_COUNT];
    logic [63:0] shadow_seq[ofsb_pkg::SLOT_COUNT];
    logic [31:0] shadow_payload[ofsb_pkg::SLOT_COUNT];
    logic        shadow_boundary[ofsb_pkg::SLOT_COUNT];
    logic        shadow_reset_mark[ofsb_pkg::SLOT_COUNT];
    logic [63:0] shadow_gen[ofsb_pkg::SLOT_COUNT];
    logic [63:0] event_count[6];
    logic [3:0]  high_water;

    int accepted_cnt = 0;
    int issued_cnt = 0;
    int mismatch_cnt = 0;
    int unexpected_cnt = 0;
    bit stimulus_done = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        cur = '{default: '0};
    end

    oldest_first_slot_buffer_with_eviction i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .done             (done),
        .kind             (cur.kind),
        .item_sequence    (cur.sequence_tag),
        .item_payload     (cur.payload),
        .item_boundary    (cur.boundary),
        .item_reset_mark  (cur.reset_mark),
        .generation       (cur.gen),
        .counter_select   (cur.sel),
        .was_published    (was_published),
        .evicted_oldest   (evicted_oldest),
        .dropped_incoming (dropped_incoming),
        .found            (found),
        .out_sequence     (out_sequence),
        .out_payload      (out_payload),
        .out_boundary     (out_boundary),
        .out_reset_mark   (out_reset_mark),
        .out_generation   (out_generation),
        .ready_count      (ready_count),
        .counter_value    (counter_value)
    );

    assign seen = {was_published, evicted_oldest, dropped_incoming, found, out_sequence,
                   out_payload, out_boundary, out_reset_mark, out_generation, ready_count,
                   counter_value};

    function automatic int count_ready_slots();
        int n;
        n = 0;
        for (int i = 0; i < ofsb_pkg::SLOT_COUNT; i++)
        begin
            if (shadow_ready[i])
                n++;
        end
        return n;
    endfunction

    // Ready slot with the smallest sequence, boundary items skipped if asked; an all-ones sequence never wins,
    // and the lowest index wins a tie. SLOT_COUNT means there is none.
    function automatic int oldest_slot(bit skip_boundary);
        logic [63:0] best;
        int idx;
        best = SEQ_NEVER;
        idx = ofsb_pkg::SLOT_COUNT;
        for (int i = 0; i < ofsb_pkg::SLOT_COUNT; i++)
        begin
            if (shadow_ready[i] && !(skip_boundary && shadow_boundary[i])
                && shadow_seq[i] < best)
            begin
                best = shadow_seq[i];
                idx = i;
            end
        end
        return idx;
    endfunction

    // Applies one accepted command to the shadow buffer and queues its result.
    task automatic apply_command(command_t c);
        outcome_t r;
        int idx;
        bit evict;
        bit keep;
        r = '0;
        idx = ofsb_pkg::SLOT_COUNT;
        evict = 1'b0;
        case (c.kind)
            ofsb_pkg::KIND_PUBLISH:
            begin
                event_count[ofsb_pkg::SEL_ATTEMPTED]++;
                for (int i = ofsb_pkg::SLOT_COUNT - 1; i >= 0; i--)
                begin
                    if (!shadow_ready[i])
                        idx = i;
                end
                if (idx == ofsb_pkg::SLOT_COUNT)
                begin
                    idx = oldest_slot(1'b1);
                    evict = (idx != ofsb_pkg::SLOT_COUNT);
                end
                if (idx == ofsb_pkg::SLOT_COUNT)
                begin
                    event_count[ofsb_pkg::SEL_DROPPED]++;
                    r.dropped = 1'b1;
                end
                else
                begin
                    shadow_seq[idx] = c.sequence_tag;
                    shadow_payload[idx] = c.payload;
                    shadow_boundary[idx] = c.boundary;
                    shadow_reset_mark[idx] = c.reset_mark;
                    shadow_gen[idx] = c.gen;
                    shadow_ready[idx] = 1'b1;
                    event_count[ofsb_pkg::SEL_PUBLISHED]++;
                    if (evict)
                        event_count[ofsb_pkg::SEL_RECLAIMED]++;
                    if (count_ready_slots() > high_water)
                        high_water = 4'(count_ready_slots());
                    r.published = 1'b1;
                    r.evicted = evict;
                end
            end
            ofsb_pkg::KIND_CONSUME:
            begin
                idx = oldest_slot(1'b0);
                if (idx != ofsb_pkg::SLOT_COUNT)
                begin
                    r.got_item = 1'b1;
                    r.sequence_tag = shadow_seq[idx];
                    r.payload = shadow_payload[idx];
                    r.boundary = shadow_boundary[idx];
                    r.reset_mark = shadow_reset_mark[idx];
                    r.gen = shadow_gen[idx];
                    shadow_ready[idx] = 1'b0;
                    event_count[ofsb_pkg::SEL_CONSUMED]++;
                end
            end
            ofsb_pkg::KIND_DISC, ofsb_pkg::KIND_DISC_KB:
            begin
                for (int i = 0; i < ofsb_pkg::SLOT_COUNT; i++)
                begin
                    keep = c.kind == ofsb_pkg::KIND_DISC_KB && c.gen != 64'd0
                        && shadow_boundary[i] && shadow_reset_mark[i]
                        && shadow_gen[i] == c.gen;
                    if (shadow_ready[i] && !keep)
                    begin
                        shadow_ready[i] = 1'b0;
                        event_count[ofsb_pkg::SEL_DISCARDED]++;
                    end
                end
            end
            ofsb_pkg::KIND_READ:
            begin
                if (c.sel == ofsb_pkg::SEL_HIGH)
                    r.counter = 64'(high_water);
                else if (c.sel != SEL_UNUSED)
                    r.counter = event_count[c.sel];
            end
            default:
            begin
                // Unused kinds leave everything alone.
            end
        endcase
        r.ready_cnt = 4'(count_ready_slots());
        expected_outcomes.push_back(r);
    endtask

    function automatic command_t make_command(logic [2:0] kind, logic [63:0] sequence_tag,
                                              logic boundary, logic reset_mark,
                                              logic [63:0] gen, logic [2:0] sel);
        command_t c;
        c.kind = kind;
        c.sequence_tag = sequence_tag;
        c.payload = $urandom;
        c.boundary = boundary;
        c.reset_mark = reset_mark;
        c.gen = gen;
        c.sel = sel;
        c.drain_first = 1'b0;
        return c;
    endfunction

    // Random command. Sequences and generations mostly come from a narrow
    // range so that ties, evictions and kept boundary items happen often.
    function automatic command_t random_command();
        command_t c;
        int pick;
        logic [2:0] kind;
        logic [63:0] sequence_tag;
        logic [63:0] gen;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            kind = ofsb_pkg::KIND_PUBLISH;
        else if (pick < 72)
            kind = ofsb_pkg::KIND_CONSUME;
        else if (pick < 77)
            kind = ofsb_pkg::KIND_DISC;
        else if (pick < 84)
            kind = ofsb_pkg::KIND_DISC_KB;
        else if (pick < 96)
            kind = ofsb_pkg::KIND_READ;
        else
            kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        pick = $urandom_range(0, 9);
        if (pick < 6)
            sequence_tag = 64'($urandom_range(0, 40));
        else if (pick < 7)
            sequence_tag = SEQ_NEVER;
        else
            sequence_tag = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        gen = (pick < 8) ? 64'($urandom_range(0, 3)) : {$urandom, $urandom};
        c = make_command(kind, sequence_tag, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), gen, 3'($urandom_range(0, 7)));
        return c;
    endfunction

    initial
    begin
        command_t c;
        for (int i = 0; i < ofsb_pkg::SLOT_COUNT; i++)
        begin
            shadow_ready[i] = 1'b0;
        end
        for (int i = 0; i < 6; i++)
        begin
            event_count[i] = '0;
        end
        high_water = '0;

        // Empty buffer: nothing to consume, unused select and unused kinds.
        pending_cmds.push_back(make_command(ofsb_pkg::KIND_CONSUME, 64'd0, 1'b0, 1'b0, 64'd0,
                                            ofsb_pkg::SEL_ATTEMPTED));
        pending_cmds.push_back(make_command(ofsb_pkg::KIND_READ, 64'd0, 1'b0, 1'b0, 64'd0,
                                            SEL_UNUSED));
        pending_cmds.push_back(make_command(KIND_UNUSED_LO, 64'd0, 1'b0, 1'b0, 64'd0,
                                            ofsb_pkg::SEL_ATTEMPTED));
        pending_cmds.push_back(make_command(KIND_UNUSED_HI, SEQ_NEVER, 1'b1, 1'b1, SEQ_NEVER,
                                            SEL_UNUSED));
        // Fill every slot; slot 0 holds an all-ones sequence that is never picked.
        for (int i = 0; i < ofsb_pkg::SLOT_COUNT; i++)
        begin
            c = make_command(ofsb_pkg::KIND_PUBLISH, (i == 0) ? SEQ_NEVER : 64'(i * 10),
                             i >= 4, i >= 6, (i >= 6) ? 64'd5 : 64'd0,
                             ofsb_pkg::SEL_ATTEMPTED);
            if (i == 7)
                c.payload = 32'hFFFF_FFFF;
            pending_cmds.push_back(c);
        end
        // Full buffer: evictions of the oldest plain items, then a drop.
        for (int i = 0; i < 4; i++)
        begin
            pending_cmds.push_back(make_command(ofsb_pkg::KIND_PUBLISH, 64'd0, 1'b1, 1'b0,
                                                SEQ_NEVER, ofsb_pkg::SEL_ATTEMPTED));
        end
        pending_cmds.push_back(make_command(ofsb_pkg::KIND_CONSUME, 64'd0, 1'b0, 1'b0, 64'd0,
                                            ofsb_pkg::SEL_ATTEMPTED));
        pending_cmds.push_back(make_command(ofsb_pkg::KIND_DISC_KB, 64'd0, 1'b0, 1'b0, 64'd0,
                                            ofsb_pkg::SEL_ATTEMPTED));
        pending_cmds.push_back(make_command(ofsb_pkg::KIND_DISC_KB, 64'd0, 1'b0, 1'b0, 64'd5,
                                            ofsb_pkg::SEL_ATTEMPTED));
        for (int s = 0; s <= 6; s++)
        begin
            pending_cmds.push_back(make_command(ofsb_pkg::KIND_READ, 64'd0, 1'b0, 1'b0, 64'd0,
                                                3'(s)));
        end
        pending_cmds.push_back(make_command(ofsb_pkg::KIND_DISC, 64'd0, 1'b0, 1'b0, 64'd0,
                                            ofsb_pkg::SEL_ATTEMPTED));
        // Wait for all earlier results to come in before the final discard.
        pending_cmds[$].drain_first = 1'b1;

        for (int n = 0; n < 1625; n++)
        begin
            c = random_command();
            if (n == 800)
                c.drain_first = 1'b1;
            pending_cmds.push_back(c);
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Driver. A new command is presented only once the previous transfer has
    // happened; in a stretch of commands the driver adds no random idle gaps, drain waits apart.
    always @(negedge clk)
    begin
        logic next_start;
        command_t next_cmd;
        next_start = start;
        next_cmd = cur;
        if (rst_n && issued_cnt == accepted_cnt)
        begin
            next_start = 1'b0;
            if (pending_cmds.size() > 0)
            begin
                if (pending_cmds[0].drain_first && expected_outcomes.size() > 0)
                    next_start = 1'b0;
                else if ((issued_cnt > 600 && issued_cnt < 900)
                         || $urandom_range(0, 99) >= 38)
                begin
                    next_cmd = pending_cmds.pop_front();
                    next_start = 1'b1;
                    issued_cnt++;
                end
            end
            else
                stimulus_done = 1'b1;
        end
        start <= next_start;
        cur <= next_cmd;
    end

    // Monitor. Takes note of accepted commands, then checks any result.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && start && !busy)
        begin
            apply_command(cur);
            accepted_cnt++;
        end
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                unexpected_cnt++;
                if (unexpected_cnt + mismatch_cnt <= 10)
                    $display("unexpected result transfer: %p", seen);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (seen !== want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt + unexpected_cnt <= 10)
                        $display("mismatch\n  expected %p\n  actual   %p", want, seen);
                end
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (expected_outcomes.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && unexpected_cnt == 0 && expected_outcomes.size() == 0)
            $display("oldest_first_slot_buffer_with_eviction verification clean");
        else
            $display("oldest_first_slot_buffer_with_eviction verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("oldest_first_slot_buffer_with_eviction verification failed");
        $finish;
    end

endmodule
